[rtl/rdct_pkg.sv]
// Shared types and constants for the reloadable down-count timer.
package rdct_pkg;

    // Request kinds carried in the slave-side tuser
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;
    localparam logic [1:0] REQ_NOP   = 2'd3;

    // Register select, address bits 5:4
    localparam logic [1:0] REG_CTRL    = 2'd0;
    localparam logic [1:0] REG_RUNNING = 2'd1;
    localparam logic [1:0] REG_FIXED   = 2'd2;
    localparam logic [1:0] REG_MATCH   = 2'd3;

    // Control subaddress operations, address bits 3:0
    localparam logic [3:0] SUB_WRITE  = 4'h0;
    localparam logic [3:0] SUB_SET    = 4'h4;
    localparam logic [3:0] SUB_CLEAR  = 4'h8;
    localparam logic [3:0] SUB_TOGGLE = 4'hC;

    // Control word field positions
    localparam int SELECT_LSB   = 0;
    localparam int SELECT_W     = 4;
    localparam int PRESCALE_LSB = 4;
    localparam int PRESCALE_W   = 2;
    localparam int RELOAD_BIT   = 6;
    localparam int UPDATE_BIT   = 7;
    localparam int IE_BIT       = 14;
    localparam int STATUS_BIT   = 15;

    // Source codes
    localparam logic [3:0] SRC_STOPPED = 4'd0;
    localparam logic [3:0] SRC_XTAL_32K = 4'd11;
    localparam logic [3:0] SRC_XTAL_8K  = 4'd12;
    localparam logic [3:0] SRC_XTAL_4K  = 4'd13;
    localparam logic [3:0] SRC_XTAL_1K  = 4'd14;
    localparam logic [3:0] SRC_BASE     = 4'd15;

    // Word widths
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 6;
    localparam int STROBE_W  = 4;
    localparam int REQ_W     = 2;
    localparam int PSC_W     = 3;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    typedef logic [DATA_W-1:0] t_word;

endpackage

[rtl/reloadable_down_count_timer_top.sv]
// Top level of the reloadable down-count timer with its register window.
//
// The block takes one word per clock while the master side keeps tready high, and returns one
// result word per input word, in order. A word is captured in the input register, is executed
// against the timer registers, and its result is held in the output register. Throughput is
// set by the update of the timer state (32-bit compare and decrement of the counter). Tick
// words stand for base-clock cycles, so the counter advances only as fast as ticks are fed in.
// The irq bit of each result is the interrupt level AND the enable bit after that word.
module reloadable_down_count_timer_top
    import rdct_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // address[5:0], write_data[37:6], crystal_strobes[41:38], zero fill [47:42]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // req_type[1:0]
    input  logic [REQ_W-1:0]       i_s_tuser,
    // master side
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // read_data[31:0], irq_out[32], zero fill [39:33]
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    // input stage
    logic                r_in_valid;
    logic [REQ_W-1:0]    r_req;
    logic [ADDR_W-1:0]   r_addr;
    t_word               r_wdata;
    logic [STROBE_W-1:0] r_strobes;

    // output stage
    logic       r_out_valid;
    t_word      r_rdata;
    logic       r_irq;

    // timer state
    t_word            r_ctrl, n_ctrl;
    t_word            r_fixed, n_fixed;
    t_word            r_match, n_match;
    t_word            r_reload, n_reload;
    t_word            r_count, n_count;
    logic             r_counting, n_counting;
    logic             r_level, n_level;
    logic             r_pending, n_pending;
    logic [PSC_W-1:0] r_psc, n_psc;

    logic       advance;
    logic       exec;
    t_word      rdata;
    logic [1:0] reg_sel;
    logic [3:0] sub_sel;
    t_word      ctrl_upd;
    logic [3:0] src;
    logic       event_hit;
    logic [PSC_W-1:0] psc_last;

    // move the pipeline when the output register is free or being drained
    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;
    assign exec       = r_in_valid && advance;

    assign reg_sel = r_addr[ADDR_W-1:4];
    assign sub_sel = r_addr[3:0];

    // capture input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_addr    <= i_s_tdata[ADDR_W-1:0];
            r_wdata   <= i_s_tdata[ADDR_W +: DATA_W];
            r_strobes <= i_s_tdata[ADDR_W+DATA_W +: STROBE_W];
            r_req     <= i_s_tuser;
        end
    end

    // apply control subaddress operation
    always_comb begin
        case (sub_sel)
            SUB_WRITE:  ctrl_upd = r_wdata;
            SUB_SET:    ctrl_upd = r_ctrl | r_wdata;
            SUB_CLEAR:  ctrl_upd = r_ctrl & ~r_wdata;
            SUB_TOGGLE: ctrl_upd = r_ctrl ^ r_wdata;
            default:    ctrl_upd = r_ctrl;
        endcase
    end

    // pick the tick source event
    assign src = r_ctrl[SELECT_LSB +: SELECT_W];
    always_comb begin
        case (src)
            SRC_BASE:     event_hit = 1'b1;
            SRC_XTAL_32K: event_hit = r_strobes[0];
            SRC_XTAL_8K:  event_hit = r_strobes[1];
            SRC_XTAL_4K:  event_hit = r_strobes[2];
            SRC_XTAL_1K:  event_hit = r_strobes[3];
            default:      event_hit = 1'b0;
        endcase
    end

    assign psc_last = (PSC_W'(1) << r_ctrl[PRESCALE_LSB +: PRESCALE_W]) - PSC_W'(1);

    // next timer state for the word in the input register
    always_comb begin
        n_ctrl     = r_ctrl;
        n_fixed    = r_fixed;
        n_match    = r_match;
        n_reload   = r_reload;
        n_count    = r_count;
        n_counting = r_counting;
        n_level    = r_level;
        n_pending  = r_pending;
        n_psc      = r_psc;
        rdata      = '0;
        case (r_req)
            REQ_READ: begin
                case (reg_sel)
                    REG_CTRL:    rdata = r_ctrl;
                    REG_RUNNING: rdata = r_count;
                    REG_FIXED:   rdata = r_fixed;
                    default:     rdata = r_match;
                endcase
            end
            REQ_WRITE: begin
                case (reg_sel)
                    REG_CTRL: begin
                        n_ctrl = ctrl_upd;
                        n_psc  = '0;
                        if (ctrl_upd[UPDATE_BIT]) begin
                            n_reload  = r_fixed;
                            n_count   = r_fixed;
                            n_pending = 1'b0;
                        end else begin
                            n_pending = 1'b1;
                        end
                        n_level    = ctrl_upd[STATUS_BIT];
                        n_counting = ctrl_upd[SELECT_LSB +: SELECT_W] != SRC_STOPPED;
                    end
                    REG_FIXED: n_fixed = r_wdata;
                    REG_MATCH: n_match = r_wdata;
                    default: ;  // running count is read-only
                endcase
            end
            REQ_TICK: begin
                if (r_counting && event_hit) begin
                    if (r_psc < psc_last) begin
                        n_psc = r_psc + PSC_W'(1);
                    end else begin
                        n_psc = '0;
                        if (r_count <= t_word'(1)) begin
                            // expire: raise level, reload or stop, then take pending load
                            n_level = 1'b1;
                            if (r_ctrl[RELOAD_BIT]) begin
                                n_count = r_reload;
                            end else begin
                                n_counting = 1'b0;
                            end
                            if (r_pending) begin
                                n_reload  = r_fixed;
                                n_count   = r_fixed;
                                n_pending = 1'b0;
                            end
                        end else begin
                            n_count = r_count - t_word'(1);
                        end
                    end
                end
            end
            default: ;  // no operation
        endcase
    end

    // commit timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl     <= '0;
            r_fixed    <= '0;
            r_match    <= '0;
            r_reload   <= '0;
            r_count    <= '0;
            r_counting <= 1'b0;
            r_level    <= 1'b0;
            r_pending  <= 1'b0;
            r_psc      <= '0;
        end else if (exec) begin
            r_ctrl     <= n_ctrl;
            r_fixed    <= n_fixed;
            r_match    <= n_match;
            r_reload   <= n_reload;
            r_count    <= n_count;
            r_counting <= n_counting;
            r_level    <= n_level;
            r_pending  <= n_pending;
            r_psc      <= n_psc;
        end
    end

    // hold result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (exec) begin
            r_rdata <= rdata;
            r_irq   <= n_level && n_ctrl[IE_BIT];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_TDATA_W-DATA_W-1)'(0), r_irq, r_rdata};

endmodule

[rtl/rdct_checker.sv]
// Port-level checker for the reloadable down-count timer, bound to its top level.
module rdct_checker
    import rdct_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic [IN_TDATA_W-1:0]  i_s_tdata,
    input logic [REQ_W-1:0]       i_s_tuser,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    // no result word right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // a stalled result word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result word changed");

    // a waiting request word holds until taken
    a_input_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && !o_s_tready |=>
            i_s_tvalid && $stable(i_s_tdata) && $stable(i_s_tuser))
        else $error("waiting request word changed");

    // with the output empty the block always takes a word
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // an accepted word passes through the input and output registers and shows as a valid result word
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |-> ##2 o_m_tvalid)
        else $error("accepted word produced no result");

endmodule

bind reloadable_down_count_timer_top rdct_checker u_rdct_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
